[rtl/core/pfish_pkg.sv]
// ----------------------------------------------------------------------------
// pfish_pkg
// Shared types, constants and the FNV-1a byte step for the frame hash block.
// ----------------------------------------------------------------------------
package pfish_pkg;

  localparam int MAX_DIM_DEFAULT = 256;
  localparam int CFG_W           = 9;    // widest configuration register
  localparam int CFG_INDEX_W     = 2;
  localparam int DIM_RESET_VAL   = 128;  // reset value of width and height
  localparam int CNT_W           = 17;
  localparam int BOUND_W         = 9;
  localparam int HASH_W          = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_ORDER = 2'd2;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'd14695981039346656037;
  localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  // Per-pixel classification carried from the front end to the back end.
  typedef struct packed {
    logic ink;        // alpha is nonzero
    logic colorful;   // the three color channels are not all equal
    logic last;       // last pixel of the frame
  } pixel_class_t;

  localparam int CLASS_W = $bits(pixel_class_t);

  // One FNV-1a step: xor in a byte, multiply by the prime.
  // The prime is 2^40 + 0x1B3, so the product is a short sum of shifts.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[rtl/core/pfish_front.sv]
// ----------------------------------------------------------------------------
// pfish_front
// Holds the frame geometry, tracks the raster position and classifies pixels.
// ----------------------------------------------------------------------------
module pfish_front
  import pfish_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int POS_W = $clog2(MAX_DIM)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   push,
  input  logic [31:0]            pixel_word,
  output pixel_class_t           cls,
  output logic [POS_W-1:0]       col,
  output logic [POS_W-1:0]       row,
  output logic                   cfg_clear,
  output logic [DIM_W-1:0]       eff_w,
  output logic [DIM_W-1:0]       eff_h
);

  localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam logic [DIM_W-1:0] DIM_RESET =
    (DIM_RESET_VAL > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(DIM_RESET_VAL);

  // Zero reads as one and anything beyond MAX_DIM is clamped.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(v);
    if (v == '0) return DIM_W'(1);
    else if (wide > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    else return DIM_W'(wide);
  endfunction

  logic col_wrap;
  logic row_wrap;

  assign col_wrap = (DIM_W'(col) + DIM_W'(1)) == eff_w;
  assign row_wrap = (DIM_W'(row) + DIM_W'(1)) == eff_h;

  assign cls.ink      = pixel_word[31:24] != 8'd0;
  assign cls.colorful = (pixel_word[7:0] != pixel_word[15:8]) ||
                        (pixel_word[15:8] != pixel_word[23:16]);
  assign cls.last     = col_wrap && row_wrap;

  always_comb begin
    unique case (cfg_index)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_CHANNEL_ORDER: cfg_clear = cfg_we;
      default:                                            cfg_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= DIM_RESET;
      eff_h <= DIM_RESET;
      col   <= '0;
      row   <= '0;
    end else if (cfg_clear) begin
      if (cfg_index == REG_FRAME_WIDTH) eff_w <= eff_dim(cfg_data);
      if (cfg_index == REG_FRAME_HEIGHT) eff_h <= eff_dim(cfg_data);
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

endmodule

[rtl/core/pfish_queue.sv]
// ----------------------------------------------------------------------------
// pfish_queue
// Two-entry queue between the classifying front end and the hashing back end.
// ----------------------------------------------------------------------------
module pfish_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/pfish_back.sv]
// ----------------------------------------------------------------------------
// pfish_back
// Folds pixel bytes into the FNV-1a hash, one byte a cycle but for result stalls,
// keeps the ink statistics and holds the finished frame result until it is taken.
// ----------------------------------------------------------------------------
module pfish_back
  import pfish_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int POS_W = $clog2(MAX_DIM)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_clear,
  input  logic [DIM_W-1:0]    eff_w,
  input  logic [DIM_W-1:0]    eff_h,
  input  logic                q_nonempty,
  input  logic [31:0]         q_word,
  input  pixel_class_t        q_cls,
  input  logic [POS_W-1:0]    q_col,
  input  logic [POS_W-1:0]    q_row,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [HASH_W-1:0]   frame_hash,
  output logic [CNT_W-1:0]    ink_count,
  output logic [CNT_W-1:0]    color_count,
  output logic [BOUND_W-1:0]  ink_left,
  output logic [BOUND_W-1:0]  ink_top,
  output logic [BOUND_W-1:0]  ink_right,
  output logic [BOUND_W-1:0]  ink_bottom
);

  logic              busy;
  logic [1:0]        step;
  logic [31:0]       cur_word;
  logic              cur_last;
  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] hash_next;
  logic [CNT_W-1:0]  ink_cnt;
  logic [CNT_W-1:0]  color_cnt;
  logic              has_ink;
  logic [POS_W-1:0]  min_col;
  logic [POS_W-1:0]  max_col;
  logic [POS_W-1:0]  min_row;
  logic [POS_W-1:0]  max_row;
  logic              out_free;
  logic              finish;
  logic              advance;

  assign hash_next = fnv_step(hash, cur_word[7:0]);
  assign out_free  = !result_valid || !result_stall;
  // The last byte of a frame's last pixel waits for room in the result register.
  assign finish    = busy && (step == 2'd3) && (!cur_last || out_free);
  assign advance   = busy && ((step != 2'd3) || finish);
  assign q_pop     = q_nonempty && (!busy || (finish && !cur_last));

  always_ff @(posedge clk) begin
    if (q_pop) cur_word <= q_word;
    else if (advance) cur_word <= {8'd0, cur_word[31:8]};
    if (q_pop) cur_last <= q_cls.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= 2'd0;
      hash      <= FNV_BASIS;
      ink_cnt   <= '0;
      color_cnt <= '0;
      has_ink   <= 1'b0;
    end else if (cfg_clear) begin
      busy      <= 1'b0;
      step      <= 2'd0;
      hash      <= FNV_BASIS;
      ink_cnt   <= '0;
      color_cnt <= '0;
      has_ink   <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (advance) begin
        step <= step + 2'd1;
      end

      if (advance) begin
        if (finish && cur_last) hash <= FNV_BASIS;
        else hash <= hash_next;
      end

      if (finish && cur_last) begin
        ink_cnt   <= '0;
        color_cnt <= '0;
        has_ink   <= 1'b0;
      end else if (q_pop && q_cls.ink) begin
        has_ink <= 1'b1;
        if (ink_cnt != CNT_MAX) ink_cnt <= ink_cnt + CNT_W'(1);
        if (q_cls.colorful && (color_cnt != CNT_MAX)) color_cnt <= color_cnt + CNT_W'(1);
      end
    end
  end

  // Bounds are only meaningful once has_ink is set; the first ink pixel loads them.
  always_ff @(posedge clk) begin
    if (q_pop && q_cls.ink) begin
      if (!has_ink || (q_col < min_col)) min_col <= q_col;
      if (!has_ink || (q_col > max_col)) max_col <= q_col;
      if (!has_ink || (q_row < min_row)) min_row <= q_row;
      if (!has_ink || (q_row > max_row)) max_row <= q_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish && cur_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && cur_last) begin
      frame_hash  <= hash_next;
      ink_count   <= ink_cnt;
      color_count <= color_cnt;
      ink_left    <= has_ink ? BOUND_W'(min_col) : BOUND_W'(eff_w);
      ink_top     <= has_ink ? BOUND_W'(min_row) : BOUND_W'(eff_h);
      ink_right   <= has_ink ? BOUND_W'(max_col) : '1;
      ink_bottom  <= has_ink ? BOUND_W'(max_row) : '1;
    end
  end

endmodule

[rtl/core/pixel_frame_ink_stats_hash.sv]
// ----------------------------------------------------------------------------
// pixel_frame_ink_stats_hash
// Per-frame FNV-1a 64 hash of a raster pixel stream, with ink counts and the
// bounding box of all pixels whose alpha is nonzero.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                    Payload
//   pixel     in         pixel_valid / pixel_stall    pixel_word
//   result    out        result_valid / result_stall  frame_hash, ink_count,
//                                                     color_count, ink_left,
//                                                     ink_top, ink_right,
//                                                     ink_bottom
//   cfg       in         cfg_we (no wait)             cfg_index, cfg_data
//
// The back end folds each pixel into the hash one byte per cycle, while a
// stalled result does not hold it, and is handed the next pixel as the last
// byte of the one before goes in. The first pixel after a frame result is
// handed over only once the previous frame's result has been registered.
// Reset is synchronous and active high; it restores a 128 by 128 geometry and
// an empty frame. There is no clearing pass.
// A stalled result holds the back end on the final byte of the next frame's
// last pixel; meanwhile the two-entry queue takes at most two more pixel
// transfers before pixel_stall rises.
//
module pixel_frame_ink_stats_hash
  import pfish_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic [31:0]            pixel_word,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [HASH_W-1:0]      frame_hash,
  output logic [CNT_W-1:0]       ink_count,
  output logic [CNT_W-1:0]       color_count,
  output logic [BOUND_W-1:0]     ink_left,
  output logic [BOUND_W-1:0]     ink_top,
  output logic [BOUND_W-1:0]     ink_right,
  output logic [BOUND_W-1:0]     ink_bottom
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int ENTRY_W = 32 + CLASS_W + 2 * POS_W;

  // Red and blue only trade places under channel_order, and neither the hash
  // (which covers the raw word) nor the three-way color compare depends on
  // which is which. A write to that register still restarts the frame.

  pixel_class_t     f_cls;
  logic [POS_W-1:0] f_col;
  logic [POS_W-1:0] f_row;
  logic             cfg_clear;
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic             push;

  logic               q_full;
  logic               q_nonempty;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_in;
  logic [ENTRY_W-1:0] q_out;

  logic [31:0]        q_word;
  pixel_class_t       q_cls;
  logic [POS_W-1:0]   q_col;
  logic [POS_W-1:0]   q_row;

  // A pixel transfer happens whenever pixel_valid is high and the queue has room.
  assign pixel_stall = q_full;
  assign push        = pixel_valid && !q_full;

  pfish_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .pixel_word (pixel_word),
    .cls        (f_cls),
    .col        (f_col),
    .row        (f_row),
    .cfg_clear  (cfg_clear),
    .eff_w      (eff_w),
    .eff_h      (eff_h)
  );

  assign q_in = {pixel_word, f_cls, f_col, f_row};

  pfish_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_out)
  );

  assign {q_word, q_cls, q_col, q_row} = q_out;

  pfish_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_clear    (cfg_clear),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .q_nonempty   (q_nonempty),
    .q_word       (q_word),
    .q_cls        (q_cls),
    .q_col        (q_col),
    .q_row        (q_row),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .frame_hash   (frame_hash),
    .ink_count    (ink_count),
    .color_count  (color_count),
    .ink_left     (ink_left),
    .ink_top      (ink_top),
    .ink_right    (ink_right),
    .ink_bottom   (ink_bottom)
  );

endmodule

[sim/pixel_frame_checker.sv]
// ----------------------------------------------------------------------------
// pixel_frame_checker
// Watches the pixel, result and register ports of the frame hash block. It
// keeps its own copy of the frame state and checks every result it sees.
// ----------------------------------------------------------------------------
module pixel_frame_checker
  import pfish_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   pixel_valid,
  input  logic                   pixel_stall,
  input  logic [31:0]            pixel_word,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  logic [HASH_W-1:0]      frame_hash,
  input  logic [CNT_W-1:0]       ink_count,
  input  logic [CNT_W-1:0]       color_count,
  input  logic [BOUND_W-1:0]     ink_left,
  input  logic [BOUND_W-1:0]     ink_top,
  input  logic [BOUND_W-1:0]     ink_right,
  input  logic [BOUND_W-1:0]     ink_bottom,
  output int                     errors,
  output int                     pending,
  output int                     frames_checked
);

  typedef struct {
    logic [HASH_W-1:0]  hash;
    logic [CNT_W-1:0]   inks;
    logic [CNT_W-1:0]   colors;
    logic [BOUND_W-1:0] x_lo;
    logic [BOUND_W-1:0] y_lo;
    logic [BOUND_W-1:0] x_hi;
    logic [BOUND_W-1:0] y_hi;
  } frame_stats_t;

  frame_stats_t expected_frames[$];
  frame_stats_t want;

  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;
  logic [HASH_W-1:0] hash_acc;
  logic [31:0]       px;
  int col, row, ink_total, color_total, min_x, min_y, max_x, max_y;
  int fail_count = 0;
  int checked = 0;

  // Out-of-range sizes are clamped to the 1..MAX_DIM range.
  function automatic int dim_in_use(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic restart_frame();
    hash_acc    = FNV_BASIS;
    col         = 0;
    row         = 0;
    ink_total   = 0;
    color_total = 0;
    min_x       = dim_in_use(width_reg);
    min_y       = dim_in_use(height_reg);
    max_x       = -1;
    max_y       = -1;
  endtask

  task automatic check_field(input string what, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (exp_val !== got_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = DIM_RESET_VAL;
      height_reg = DIM_RESET_VAL;
      expected_frames.delete();
      restart_frame();
    end else begin
      // Any write to a defined register throws away the frame in progress.
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
            restart_frame();
          end
          REG_CHANNEL_ORDER: begin
            restart_frame();
          end
          default: ;
        endcase
      end

      if (pixel_valid && !pixel_stall) begin
        px = pixel_word;
        for (int b = 0; b < 4; b++) begin
          hash_acc = (hash_acc ^ {56'd0, px[8*b +: 8]}) * FNV_PRIME;
        end
        // Red and blue only swap places, so the channel order never matters.
        if (px[31:24] != 8'd0) begin
          if (ink_total < CNT_MAX) ink_total++;
          if ((px[7:0] != px[15:8] || px[15:8] != px[23:16]) && color_total < CNT_MAX)
            color_total++;
          if (col < min_x) min_x = col;
          if (row < min_y) min_y = row;
          if (col > max_x) max_x = col;
          if (row > max_y) max_y = row;
        end
        col++;
        if (col >= dim_in_use(width_reg)) begin
          col = 0;
          row++;
          if (row >= dim_in_use(height_reg)) begin
            want.hash   = hash_acc;
            want.inks   = CNT_W'(ink_total);
            want.colors = CNT_W'(color_total);
            want.x_lo   = BOUND_W'(min_x);
            want.y_lo   = BOUND_W'(min_y);
            want.x_hi   = BOUND_W'(max_x);
            want.y_hi   = BOUND_W'(max_y);
            expected_frames.insert(expected_frames.size(), want);
            restart_frame();
          end
        end
      end

      if (result_valid && !result_stall) begin
        if (expected_frames.size() == 0) begin
          fail_count++;
          $display("%0t: frame result with nothing expected, expected none, actual hash %h",
                   $time, frame_hash);
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_hash", want.hash, frame_hash);
          check_field("ink_count", want.inks, ink_count);
          check_field("color_count", want.colors, color_count);
          check_field("ink_left", want.x_lo, ink_left);
          check_field("ink_top", want.y_lo, ink_top);
          check_field("ink_right", want.x_hi, ink_right);
          check_field("ink_bottom", want.y_hi, ink_bottom);
          checked++;
        end
      end
    end
    errors         <= fail_count;
    pending        <= expected_frames.size();
    frames_checked <= checked;
  end

endmodule

[sim/tb_pixel_frame_ink_stats_hash.sv]
// ----------------------------------------------------------------------------
// tb_pixel_frame_ink_stats_hash
// Streams pixel frames of many geometries into the frame hash block, with
// random idle cycles on the pixel side and random stalls on the result side.
// A checker beside the block predicts and compares every frame result.
// ----------------------------------------------------------------------------
module tb_pixel_frame_ink_stats_hash;
  import pfish_pkg::*;

  // The block holds at most two queued pixels and one in the back end, so the
  // wait below is ample for it to fall quiet.
  localparam int DRAIN_CYCLES  = 32;
  localparam int RANDOM_PIXELS = 400;

  // Index 3 is not a register; a write there must leave the frame alone.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]       cfg_data     = '0;
  logic                   pixel_valid  = 1'b0;
  logic [31:0]            pixel_word   = '0;
  logic                   result_stall = 1'b0;

  logic                   pixel_stall;
  logic                   result_valid;
  logic [HASH_W-1:0]      frame_hash;
  logic [CNT_W-1:0]       ink_count;
  logic [CNT_W-1:0]       color_count;
  logic [BOUND_W-1:0]     ink_left;
  logic [BOUND_W-1:0]     ink_top;
  logic [BOUND_W-1:0]     ink_right;
  logic [BOUND_W-1:0]     ink_bottom;

  int check_errors;
  int results_waiting;
  int frames_checked;

  // When idle_on is low, neither side inserts gaps: back-to-back stretches.
  bit idle_on = 1'b1;
  int pixels_sent = 0;
  int settings_used = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_frame_ink_stats_hash uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_word   (pixel_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .frame_hash   (frame_hash),
    .ink_count    (ink_count),
    .color_count  (color_count),
    .ink_left     (ink_left),
    .ink_top      (ink_top),
    .ink_right    (ink_right),
    .ink_bottom   (ink_bottom)
  );

  pixel_frame_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .pixel_word     (pixel_word),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .frame_hash     (frame_hash),
    .ink_count      (ink_count),
    .color_count    (color_count),
    .ink_left       (ink_left),
    .ink_top        (ink_top),
    .ink_right      (ink_right),
    .ink_bottom     (ink_bottom),
    .errors         (check_errors),
    .pending        (results_waiting),
    .frames_checked (frames_checked)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Size that the block actually uses for a register value.
  function automatic int effective(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return int'(v);
  endfunction

  // A random pixel with the given chance of ink. The color channels are
  // often made partly or fully equal so that both gray and colored ink occur.
  function automatic logic [31:0] make_pixel(input int ink_pct);
    logic [7:0] a, c0, c1, c2;
    a  = ($urandom_range(0, 99) < ink_pct) ? 8'($urandom_range(1, 255)) : 8'd0;
    c0 = 8'($urandom);
    c1 = 8'($urandom);
    c2 = 8'($urandom);
    case ($urandom_range(0, 4))
      0: begin
        c1 = c0;
        c2 = c0;
      end
      1: c1 = c0;
      2: c2 = c1;
      3: c2 = c0;
      default: ;
    endcase
    return {a, c2, c1, c0};
  endfunction

  // One pixel transfer. Valid stays high from one transfer to the next when
  // no gap is drawn, so it is never dropped and raised in the same step.
  task automatic send_pixel(input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_word  <= word;
    do @(posedge clk); while (pixel_stall);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int count, input int ink_pct);
    repeat (count) send_pixel(make_pixel(ink_pct));
  endtask

  // Register write; the caller lowers the write enable after its last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic order);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CHANNEL_ORDER, {{(CFG_W-1){1'b0}}, order});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Stop sending, wait for every expected frame, then give the block time to
  // finish any pixels of an unfinished frame before the next register write.
  task automatic settle();
    pixel_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stall bursts, driven at the rising edge.
  initial begin : result_sink
    int hold;
    forever begin
      @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  // Single-pixel frames: the extremes of the word, empty and inked pixels,
  // gray ink and each way in which one channel can differ from the others.
  logic [31:0] corner_words [11] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0100_0000, 32'hFF00_0000, 32'h00FF_FFFF,
    32'h0012_3456, 32'h8011_2211, 32'h4033_3322, 32'h2044_5555, 32'h7FAB_ABAB,
    32'hA55A_A55A
  };

  initial begin : stimulus
    logic [CFG_W-1:0] w_raw, h_raw;
    int frame_len, ink_pct, partial, n_frames;
    int random_pixels;

    random_pixels = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Only the width changes, so the height is still its reset value and a
    // frame is one column of 128 rows.
    write_reg(REG_FRAME_WIDTH, 9'd1);
    cfg_we <= 1'b0;
    settings_used++;
    send_pixels(128, 10);
    settle();

    // A width of zero is taken as one: every pixel is a frame of its own.
    configure(9'd0, 9'd1, 1'b0);
    foreach (corner_words[i]) send_pixel(corner_words[i]);
    settle();

    // Width above the maximum clamps to 256 and height zero to one. Ink sits
    // only in the first and last column.
    configure(9'd511, 9'd0, 1'b1);
    for (int i = 0; i < 256; i++) begin
      send_pixel((i == 0 || i == 255) ? 32'h80FF_0000 : 32'h0000_0000);
    end
    settle();

    // One column of the largest height, with ink on a single row.
    configure(9'd1, 9'd256, 1'b0);
    for (int i = 0; i < 256; i++) begin
      send_pixel((i == 7) ? 32'h0101_0101 : 32'h00FF_00FF);
    end
    settle();

    // A register write in the middle of a frame throws the partial frame
    // away; a write to the unused index does not.
    configure(9'd3, 9'd3, 1'b0);
    send_pixels(4, 50);
    settle();
    write_reg(REG_CHANNEL_ORDER, 9'd1);
    cfg_we <= 1'b0;
    send_pixels(2, 50);
    settle();
    write_reg(REG_UNUSED, 9'($urandom));
    cfg_we <= 1'b0;
    send_pixels(7, 50);
    settle();

    // Random geometries and content; mostly small frames so that results are
    // frequent, now and then a clamped or a long narrow one.
    while (random_pixels < RANDOM_PIXELS) begin
      case ($urandom_range(0, 19))
        0: begin
          w_raw = 9'($urandom_range(257, 511));
          h_raw = 9'($urandom_range(0, 1));
        end
        1: begin
          w_raw = 9'($urandom_range(0, 1));
          h_raw = 9'($urandom_range(200, 511));
        end
        2, 3: begin
          w_raw = 9'($urandom_range(13, 40));
          h_raw = 9'($urandom_range(1, 4));
        end
        default: begin
          w_raw = 9'($urandom_range(0, 12));
          h_raw = 9'($urandom_range(0, 12));
        end
      endcase
      configure(w_raw, h_raw, 1'($urandom));
      frame_len = effective(w_raw) * effective(h_raw);
      n_frames  = (frame_len > 64) ? 1 : $urandom_range(1, 4);
      repeat (n_frames) begin
        idle_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
          0: ink_pct = 0;
          1: ink_pct = 5;
          2: ink_pct = 50;
          default: ink_pct = 100;
        endcase
        send_pixels(frame_len, ink_pct);
        random_pixels += frame_len;
      end
      // Sometimes leave a frame unfinished so that the next write aborts it.
      if (frame_len > 1 && $urandom_range(0, 4) == 0) begin
        partial = $urandom_range(1, frame_len - 1);
        send_pixels(partial, 50);
        random_pixels += partial;
      end
      idle_on = 1'b1;
      settle();
    end

    $display("covered %0d pixel transfers and %0d frame results over %0d register settings",
             pixels_sent, frames_checked, settings_used);
    $display("frames up to 256 pixels along a side, clamped sizes, aborted frames, stalls");
    if (check_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin : run_limit
    #8000000;
    $display("timeout with %0d frame results still expected", results_waiting);
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/core/pfish_pkg.sv
rtl/core/pfish_front.sv
rtl/core/pfish_queue.sv
rtl/core/pfish_back.sv
rtl/core/pixel_frame_ink_stats_hash.sv
sim/pixel_frame_checker.sv
sim/tb_pixel_frame_ink_stats_hash.sv
